// File: hw/rtl/ohp_pkg.sv
// Shared types, error codes and constants for the Opus identification header parser.
package ohp_pkg;

	localparam int unsigned POS_W      = 9;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam logic [POS_W-1:0] POS_MAX     = 9'd511;
	localparam logic [POS_W-1:0] POS_VERSION = 9'd8;
	localparam logic [POS_W-1:0] POS_CHANS   = 9'd9;
	localparam logic [POS_W-1:0] POS_FAMILY  = 9'd18;
	localparam logic [POS_W-1:0] POS_STREAMS = 9'd19;
	localparam logic [POS_W-1:0] POS_COUPLED = 9'd20;
	localparam logic [POS_W-1:0] MIN_LEN     = 9'd19;
	localparam logic [9:0]       MAP_BASE    = 10'd21;
	localparam logic [7:0]       MAP_UNUSED  = 8'd255;

	localparam logic [3:0] ERR_NONE     = 4'd0;
	localparam logic [3:0] ERR_SHORT    = 4'd1;
	localparam logic [3:0] ERR_MAGIC    = 4'd2;
	localparam logic [3:0] ERR_VERSION  = 4'd3;
	localparam logic [3:0] ERR_ZERO_CH  = 4'd4;
	localparam logic [3:0] ERR_ZERO_STR = 4'd5;
	localparam logic [3:0] ERR_COUPLED  = 4'd6;
	localparam logic [3:0] ERR_MAP      = 4'd7;
	localparam logic [3:0] ERR_FAM0_CH  = 4'd8;
	localparam logic [3:0] ERR_TRAILING = 4'd9;

	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_MAP     = 1'b1;

	typedef struct packed {
		logic               kind;
		logic               header_ok;
		logic [3:0]         error_code;
		logic [7:0]         version_out;
		logic [7:0]         channel_count;
		logic [15:0]        preskip_out;
		logic [31:0]        sample_rate_out;
		logic signed [15:0] gain_out;
		logic [7:0]         mapping_family;
		logic [7:0]         stream_count;
		logic [7:0]         coupled_count;
		logic [7:0]         map_entry;
	} result_t;

	// Results produced by one byte: a map entry first, then the summary.
	typedef struct packed {
		logic    map_vld;
		logic    sum_vld;
		result_t map_res;
		result_t sum_res;
	} push_t;

	// "OpusHead" magic, one character per position.
	function automatic logic [7:0] magic_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h4F;
			3'd1: c = 8'h70;
			3'd2: c = 8'h75;
			3'd3: c = 8'h73;
			3'd4: c = 8'h48;
			3'd5: c = 8'h65;
			3'd6: c = 8'h61;
			3'd7: c = 8'h64;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: hw/rtl/ohp_in_if.sv
// Byte channel of the header parser: valid/ready plus one header byte.
interface ohp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/ohp_out_if.sv
// Result channel of the header parser: valid/ready plus one result item.
interface ohp_out_if;
	logic               valid;
	logic               ready;
	logic               kind;
	logic               header_ok;
	logic [3:0]         error_code;
	logic [7:0]         version_out;
	logic [7:0]         channel_count;
	logic [15:0]        preskip_out;
	logic [31:0]        sample_rate_out;
	logic signed [15:0] gain_out;
	logic [7:0]         mapping_family;
	logic [7:0]         stream_count;
	logic [7:0]         coupled_count;
	logic [7:0]         map_entry;

	modport source(output valid, input ready, output kind, output header_ok,
		output error_code, output version_out, output channel_count, output preskip_out,
		output sample_rate_out, output gain_out, output mapping_family,
		output stream_count, output coupled_count, output map_entry);
	modport sink(input valid, output ready, input kind, input header_ok,
		input error_code, input version_out, input channel_count, input preskip_out,
		input sample_rate_out, input gain_out, input mapping_family,
		input stream_count, input coupled_count, input map_entry);
endinterface

// File: hw/rtl/ohp_core.sv
// Header field state and per-byte checks; produces the results of one byte.
module ohp_core
	import ohp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output push_t      push
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       version_q, channels_q, family_q, streams_q, coupled_q;
	logic [15:0]      preskip_q, gain_q;
	logic [31:0]      rate_q;
	logic [3:0]       err_q;

	logic [POS_W-1:0] pos_d;
	logic [7:0]       version_d, channels_d, family_d, streams_d, coupled_d;
	logic [15:0]      preskip_d, gain_d;
	logic [31:0]      rate_d;
	logic [3:0]       byte_err, err_d, err_final;
	logic             map_hit, short_pkt;
	logic [9:0]       map_end, map_end_d;
	logic [8:0]       map_limit, pair_sum;

	always_comb begin
		version_d  = version_q;
		channels_d = channels_q;
		family_d   = family_q;
		streams_d  = streams_q;
		coupled_d  = coupled_q;
		preskip_d  = preskip_q;
		gain_d     = gain_q;
		rate_d     = rate_q;
		byte_err   = ERR_NONE;
		map_hit    = 1'b0;
		map_end    = MAP_BASE + {2'b00, channels_q};
		map_limit  = {1'b0, streams_q} + {1'b0, coupled_q};
		pair_sum   = {1'b0, data_byte} + {1'b0, streams_q};

		if (pos_q < POS_VERSION) begin
			if (data_byte != magic_char(pos_q[2:0]))
				byte_err = ERR_MAGIC;
		end else if (pos_q == POS_VERSION) begin
			version_d = data_byte;
			if (data_byte[7:4] != 4'd0)
				byte_err = ERR_VERSION;
		end else if (pos_q == POS_CHANS) begin
			channels_d = data_byte;
			if (data_byte == 8'd0)
				byte_err = ERR_ZERO_CH;
		end else if (pos_q <= 9'd11) begin
			if (pos_q[0])
				preskip_d[15:8] = data_byte;
			else
				preskip_d[7:0] = data_byte;
		end else if (pos_q <= 9'd15) begin
			case (pos_q[1:0])
				2'd0:    rate_d[7:0]   = data_byte;
				2'd1:    rate_d[15:8]  = data_byte;
				2'd2:    rate_d[23:16] = data_byte;
				default: rate_d[31:24] = data_byte;
			endcase
		end else if (pos_q <= 9'd17) begin
			if (pos_q[0])
				gain_d[15:8] = data_byte;
			else
				gain_d[7:0] = data_byte;
		end else if (pos_q == POS_FAMILY) begin
			family_d = data_byte;
			if (data_byte == 8'd0) begin
				streams_d = 8'd1;
				coupled_d = (channels_q > 8'd1) ? 8'd1 : 8'd0;
				if (channels_q > 8'd2)
					byte_err = ERR_FAM0_CH;
			end
		end else if (family_q == 8'd0 || {1'b0, pos_q} >= map_end) begin
			if (version_q <= 8'd1)
				byte_err = ERR_TRAILING;
		end else if (pos_q == POS_STREAMS) begin
			streams_d = data_byte;
			if (data_byte == 8'd0)
				byte_err = ERR_ZERO_STR;
		end else if (pos_q == POS_COUPLED) begin
			coupled_d = data_byte;
			if (data_byte > streams_q || pair_sum > 9'd255)
				byte_err = ERR_COUPLED;
		end else begin
			map_hit = (err_q == ERR_NONE);
			if ({1'b0, data_byte} >= map_limit && data_byte != MAP_UNUSED)
				byte_err = ERR_MAP;
		end

		err_d = (err_q != ERR_NONE) ? err_q : byte_err;
		pos_d = (pos_q < POS_MAX) ? pos_q + 9'd1 : pos_q;

		// Length is judged on the count including this byte and the updated fields.
		map_end_d = MAP_BASE + {2'b00, channels_d};
		short_pkt = (pos_d < MIN_LEN) || (family_d != 8'd0 && {1'b0, pos_d} < map_end_d);
		err_final = (err_d == ERR_NONE && short_pkt) ? ERR_SHORT : err_d;

		push = '0;
		push.map_vld               = step && map_hit;
		push.map_res.kind          = KIND_MAP;
		push.map_res.map_entry     = data_byte;
		push.sum_vld               = step && last_byte;
		push.sum_res.kind          = KIND_SUMMARY;
		push.sum_res.header_ok     = (err_final == ERR_NONE);
		push.sum_res.error_code    = err_final;
		push.sum_res.version_out   = version_d;
		push.sum_res.channel_count = channels_d;
		push.sum_res.preskip_out   = preskip_d;
		push.sum_res.sample_rate_out = rate_d;
		push.sum_res.gain_out      = gain_d;
		push.sum_res.mapping_family = family_d;
		push.sum_res.stream_count  = streams_d;
		push.sum_res.coupled_count = coupled_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			version_q  <= '0;
			channels_q <= '0;
			preskip_q  <= '0;
			rate_q     <= '0;
			gain_q     <= '0;
			family_q   <= '0;
			streams_q  <= '0;
			coupled_q  <= '0;
			err_q      <= ERR_NONE;
		end else if (step) begin
			if (last_byte) begin
				pos_q      <= '0;
				version_q  <= '0;
				channels_q <= '0;
				preskip_q  <= '0;
				rate_q     <= '0;
				gain_q     <= '0;
				family_q   <= '0;
				streams_q  <= '0;
				coupled_q  <= '0;
				err_q      <= ERR_NONE;
			end else begin
				pos_q      <= pos_d;
				version_q  <= version_d;
				channels_q <= channels_d;
				preskip_q  <= preskip_d;
				rate_q     <= rate_d;
				gain_q     <= gain_d;
				family_q   <= family_d;
				streams_q  <= streams_d;
				coupled_q  <= coupled_d;
				err_q      <= err_d;
			end
		end
	end

endmodule

// File: hw/rtl/ohp_queue.sv
// Small result queue that takes up to two results per cycle and gives one.
module ohp_queue
	import ohp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	input  logic              pop,
	output logic              valid,
	output result_t           head,
	output logic [QCNT_W-1:0] count
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_nx;
	logic [QCNT_W-1:0] cnt_q;
	logic [QCNT_W-1:0] n_push;
	logic              do_pop;

	assign valid   = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign count   = cnt_q;
	assign do_pop  = pop && valid;
	assign n_push  = QCNT_W'(push.map_vld) + QCNT_W'(push.sum_vld);
	assign wr_ptr_nx = wr_ptr_q + QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.map_vld) begin
			mem_q[wr_ptr_q] <= push.map_res;
			if (push.sum_vld)
				mem_q[wr_ptr_nx] <= push.sum_res;
		end else if (push.sum_vld) begin
			mem_q[wr_ptr_q] <= push.sum_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[QPTR_W-1:0];
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + n_push - QCNT_W'(do_pop);
		end
	end

endmodule

// File: hw/rtl/opus_id_header_parser_unit.sv
// Top level of the Opus identification header parser: byte stage, parser core, result queue.
// Flow: an accepted byte is registered in the byte stage and checked by the core once the queue
// has room for two results; its results are then written into the queue and offered from its head.
// Throughput: one byte per cycle; a final byte that also carries a map entry gives two results,
// which drain one per cycle from the four-entry queue; bytes stall while it holds three or more.
// Reset: arst_n clears the byte stage, all header fields, the error and the queue pointers.
module opus_id_header_parser_unit
	import ohp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	ohp_in_if.sink      byte_ch,
	ohp_out_if.source   result_ch
);

	// Byte stage: holds one accepted beat until the queue has room for both
	// results it may cause. Room for two keeps a steady one-beat-per-cycle flow
	// while the consumer takes results, and stalls cleanly when it does not.
	// After each summary the parser returns to its reset state for the next packet.
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic              fire_s1;
	logic [QCNT_W-1:0] q_count;
	logic              q_valid;
	result_t           q_head;
	push_t             push;

	assign fire_s1       = valid_s1 && (q_count <= QCNT_W'(QUEUE_DEPTH - 2));
	assign byte_ch.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			byte_s1 <= byte_ch.data_byte;
			last_s1 <= byte_ch.last_byte;
		end
	end

	// The core checks the staged byte against its position and the fields seen
	// so far, and hands over a map entry and/or a summary.
	ohp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (fire_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.push      (push)
	);

	// The queue decouples the result side; results leave in the order produced.
	ohp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (result_ch.ready),
		.valid  (q_valid),
		.head   (q_head),
		.count  (q_count)
	);

	assign result_ch.valid           = q_valid;
	assign result_ch.kind            = q_head.kind;
	assign result_ch.header_ok       = q_head.header_ok;
	assign result_ch.error_code      = q_head.error_code;
	assign result_ch.version_out     = q_head.version_out;
	assign result_ch.channel_count   = q_head.channel_count;
	assign result_ch.preskip_out     = q_head.preskip_out;
	assign result_ch.sample_rate_out = q_head.sample_rate_out;
	assign result_ch.gain_out        = q_head.gain_out;
	assign result_ch.mapping_family  = q_head.mapping_family;
	assign result_ch.stream_count    = q_head.stream_count;
	assign result_ch.coupled_count   = q_head.coupled_count;
	assign result_ch.map_entry       = q_head.map_entry;

	// The queue never holds more than its depth.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	// Results are produced only by a byte that leaves the byte stage.
	a_push_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(push.map_vld || push.sum_vld) |-> fire_s1)
		else $error("result produced without a staged byte");

	// A summary is accepted exactly when it carries no error code.
	a_summary_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		push.sum_vld |-> (push.sum_res.header_ok == (push.sum_res.error_code == ERR_NONE)))
		else $error("summary ok flag disagrees with error code");

	// A byte that pushes both a map entry and a summary while nothing is popped raises the queue count by two next cycle.
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push.map_vld && push.sum_vld && !(result_ch.ready && q_valid))
		|=> q_count == $past(q_count) + QCNT_W'(2))
		else $error("queue count lost a result");

endmodule
